>>> design/fcb_pkg.sv
`default_nettype none
package fcb_pkg;
  localparam int unsigned DebounceReset = 500000;
  localparam logic [4:0]  Io1PageHi     = 5'd30;

  typedef enum logic [1:0] {
    REQ_BUS  = 2'd0,
    REQ_ROM  = 2'd1,
    REQ_KERN = 2'd2,
    REQ_NONE = 2'd3
  } req_t;

  typedef enum logic [0:0] {
    CFG_HAS_KERNAL = 1'b0,
    CFG_DEBOUNCE   = 1'b1
  } cfg_idx_t;

  // classified item handed from front to back
  typedef struct packed {
    req_t        req;
    logic        cpu_write;
    logic        roml_sel;
    logic        romh_sel;
    logic        io1_sel;
    logic        kernal_sel;
    logic [15:0] addr;
    logic [7:0]  data;
    logic        freeze_button;
  } item_t;
endpackage
`default_nettype wire

>>> design/fcb_front.sv
`default_nettype none
module fcb_front
  import fcb_pkg::*;
#(
  parameter int Depth = 2
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire item_t  in_item,
  output logic        q_valid,
  input  wire         q_ready,
  output item_t       q_item
);
  localparam int Aw = (Depth > 1) ? $clog2(Depth) : 1;

  item_t          fifo [Depth];
  logic [Aw-1:0]  wp, rp;
  logic [Aw:0]    cnt;
  logic           push, pop;

  assign in_ready = (cnt != Aw'(0) + (Aw+1)'(Depth));
  assign q_valid  = (cnt != '0);
  assign q_item   = fifo[rp];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  // small item queue
  always_ff @(posedge clk) begin
    if (push) fifo[wp] <= in_item;
    if (rst) begin
      wp <= '0; rp <= '0; cnt <= '0;
    end else begin
      if (push) wp <= (wp == Aw'(Depth - 1)) ? '0 : wp + 1'b1;
      if (pop)  rp <= (rp == Aw'(Depth - 1)) ? '0 : rp + 1'b1;
      cnt <= cnt + (Aw+1)'(push) - (Aw+1)'(pop);
    end
  end
endmodule
`default_nettype wire

>>> design/fcb_back.sv
`default_nettype none
module fcb_back
  import fcb_pkg::*;
(
  input  wire         clk,
  input  wire         rst,
  input  wire         has_kernal,
  input  wire  [19:0] debounce_cycles,
  input  wire         q_valid,
  output logic        q_ready,
  input  wire item_t  q_item,
  output logic        out_valid,
  input  wire         out_ready,
  output logic        drive_bus,
  output logic [7:0]  read_data,
  output logic        game_line,
  output logic        exrom_line,
  output logic        nmi_line,
  output logic        led_on
);
  logic [7:0]  cart_ram [32768];
  logic [7:0]  rom_lo   [32768];
  logic [7:0]  rom_hi   [32768];
  logic [7:0]  kern_rom [8192];

  logic [1:0]  bank;
  logic        export_ram, cart_active, ultimax_mode, freeze_pending;
  logic [2:0]  write_run;
  logic [19:0] debounce_left;
  logic        game_l, exrom_l, nmi_l, led_l;

  // stage 2: pending read result
  logic        s2_valid;
  logic [1:0]  s2_sel;   // 0 zero, 1 ram, 2 rom lo, 3 rom hi; kernal via s2_kern
  logic        s2_kern, s2_drive;
  logic [7:0]  ram_q, lo_q, hi_q, kern_q;

  logic        advance;
  assign advance = !out_valid || out_ready;
  assign q_ready = advance && !s2_valid;

  // decode the head item
  item_t       it;
  logic        is_bus, wr, kern_hit, roml_rd, romh_rd, io1_rd, read_hit;
  logic [14:0] bidx, io_idx, load_idx;
  assign it       = q_item;
  assign is_bus   = (it.req == REQ_BUS);
  assign wr       = it.cpu_write;
  assign kern_hit = has_kernal && it.romh_sel && it.kernal_sel &&
                    (!ultimax_mode || !cart_active);
  assign roml_rd  = !wr && it.roml_sel;
  assign romh_rd  = !wr && it.romh_sel && cart_active;
  assign io1_rd   = !wr && it.io1_sel && cart_active;
  assign read_hit = kern_hit || roml_rd || romh_rd || io1_rd;
  assign bidx     = {bank, it.addr[12:0]};
  assign io_idx   = {bank, Io1PageHi, it.addr[7:0]};
  assign load_idx = {it.addr[15:14], it.addr[12:0]};

  // bus-cycle write path, done combinationally on control state
  logic [1:0]  bank_n;
  logic        exp_n, act_n, ult_n, fp_n;
  logic [2:0]  wr_n;
  logic [19:0] db_n;
  logic        g_n, e_n, n_n, l_n, ram_we;
  logic [2:0]  m;
  always_comb begin
    bank_n = bank; exp_n = export_ram; act_n = cart_active; ult_n = ultimax_mode;
    fp_n = freeze_pending; db_n = debounce_left;
    g_n = game_l; e_n = exrom_l; n_n = nmi_l; l_n = led_l;
    ram_we = 1'b0;
    m = {it.data[3], it.data[1:0]};
    wr_n = wr ? ((write_run < 3'd4) ? write_run + 3'd1 : write_run) : 3'd0;
    if (wr && it.io1_sel && cart_active) begin
      bank_n = {it.data[4], it.data[2]};
      l_n = !m[2]; n_n = 1'b1;
      g_n = m[0]; e_n = !m[1];
      act_n = !it.data[3];
      ult_n = (m == 3'd0) && act_n;
      exp_n = !it.data[1];
    end
    if (wr && it.roml_sel && exp_n && act_n) begin
      ram_we = 1'b1;
    end else if (it.freeze_button && debounce_left == '0) begin
      db_n = debounce_cycles; fp_n = 1'b1; wr_n = 3'd0;
      act_n = 1'b1; ult_n = 1'b1; exp_n = 1'b1; bank_n = '0;
      l_n = 1'b1; g_n = 1'b0; e_n = 1'b1; n_n = 1'b0;
    end else begin
      if (debounce_left != '0) db_n = debounce_left - 20'd1;
      if (freeze_pending && wr_n == 3'd3) begin
        e_n = 1'b1; g_n = 1'b0; ult_n = 1'b1; fp_n = 1'b0;
      end
    end
  end
  logic [14:0] ram_wa;
  assign ram_wa = {bank_n, it.addr[12:0]};

  // memories with registered reads
  always_ff @(posedge clk) begin
    ram_q  <= cart_ram[bidx];
    lo_q   <= rom_lo[it.io1_sel && !it.roml_sel && !it.romh_sel ? io_idx : bidx];
    hi_q   <= rom_hi[bidx];
    kern_q <= kern_rom[it.addr[12:0]];
    if (q_valid && q_ready) begin
      if (it.req == REQ_ROM && it.addr[13])  rom_hi[load_idx] <= it.data;
      if (it.req == REQ_ROM && !it.addr[13]) rom_lo[load_idx] <= it.data;
      if (it.req == REQ_KERN) kern_rom[it.addr[12:0]] <= it.data;
      if (is_bus && !kern_hit && !read_hit && ram_we) cart_ram[ram_wa] <= it.data;
    end
  end

  // control state and output register
  logic [7:0] rd_mux;
  always_comb begin
    case (s2_sel)
      2'd1:    rd_mux = ram_q;
      2'd2:    rd_mux = lo_q;
      2'd3:    rd_mux = hi_q;
      default: rd_mux = 8'd0;
    endcase
    if (s2_kern) rd_mux = kern_q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bank <= '0; export_ram <= 1'b1; cart_active <= 1'b1; ultimax_mode <= 1'b1;
      write_run <= '0; freeze_pending <= 1'b0; debounce_left <= '0;
      game_l <= 1'b0; exrom_l <= 1'b1; nmi_l <= 1'b1; led_l <= 1'b1;
      s2_valid <= 1'b0; out_valid <= 1'b0;
      s2_sel <= '0; s2_kern <= 1'b0; s2_drive <= 1'b0;
    end else begin
      if (s2_valid && advance) begin
        s2_valid <= 1'b0; out_valid <= 1'b1;
        drive_bus <= s2_drive;
        read_data <= s2_drive ? rd_mux : 8'd0;
        game_line <= game_l; exrom_line <= exrom_l;
        nmi_line <= nmi_l; led_on <= led_l;
      end else if (q_valid && q_ready) begin
        if (is_bus && read_hit) begin
          // any held item was taken at this edge, since advance is high
          out_valid <= 1'b0;
          s2_valid <= 1'b1; s2_drive <= 1'b1; s2_kern <= kern_hit;
          if (roml_rd) s2_sel <= export_ram ? 2'd1 : (cart_active ? 2'd2 : 2'd0);
          else if (romh_rd) s2_sel <= 2'd3;
          else s2_sel <= 2'd2;
        end else begin
          out_valid <= 1'b1; drive_bus <= 1'b0; read_data <= 8'd0;
          if (is_bus) begin
            bank <= bank_n; export_ram <= exp_n; cart_active <= act_n;
            ultimax_mode <= ult_n; write_run <= wr_n; freeze_pending <= fp_n;
            debounce_left <= db_n;
            game_l <= g_n; exrom_l <= e_n; nmi_l <= n_n; led_l <= l_n;
            game_line <= g_n; exrom_line <= e_n; nmi_line <= n_n; led_on <= l_n;
          end else begin
            game_line <= game_l; exrom_line <= exrom_l;
            nmi_line <= nmi_l; led_on <= led_l;
          end
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end
endmodule
`default_nettype wire

>>> design/freezer_cartridge_bus_logic.sv
// channel | handshake               | payload
// in      | in_valid / in_ready     | req_type .. freeze_button
// out     | out_valid / out_ready   | drive_bus .. led_on
// cfg     | cfg_valid / cfg_ready   | cfg_index, cfg_data
// Non-read items go straight to the output register; reads first pass the
// registered memory read port into stage 2. Sustained rate: one item per cycle
// for writes and loads while the output is not stalled; a read holds off the next item until it leaves stage 2.
// rst is synchronous; memories keep their contents and are not cleared.
// A two-entry queue decouples input from the back end; output stalls hold it.
`default_nettype none
module freezer_cartridge_bus_logic
  import fcb_pkg::*;
#(
  parameter int QueueDepth = 2
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire  [1:0]  req_type,
  input  wire         cpu_write,
  input  wire         roml_sel,
  input  wire         romh_sel,
  input  wire         io1_sel,
  input  wire         kernal_sel,
  input  wire  [15:0] addr,
  input  wire  [7:0]  data,
  input  wire         freeze_button,
  output logic        out_valid,
  input  wire         out_ready,
  output logic        drive_bus,
  output logic [7:0]  read_data,
  output logic        game_line,
  output logic        exrom_line,
  output logic        nmi_line,
  output logic        led_on,
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [0:0]  cfg_index,
  input  wire  [19:0] cfg_data
);
  logic        has_kernal;
  logic [19:0] debounce_cycles;
  item_t       in_item, q_item;
  logic        q_valid, q_ready;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      has_kernal <= 1'b0;
      debounce_cycles <= 20'(DebounceReset);
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_HAS_KERNAL: has_kernal <= cfg_data[0];
        CFG_DEBOUNCE:   debounce_cycles <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_item = '{req: req_t'(req_type), cpu_write: cpu_write, roml_sel: roml_sel,
                     romh_sel: romh_sel, io1_sel: io1_sel, kernal_sel: kernal_sel,
                     addr: addr, data: data, freeze_button: freeze_button};

  fcb_front #(.Depth(QueueDepth)) u_front (
    .clk, .rst, .in_valid, .in_ready, .in_item,
    .q_valid, .q_ready, .q_item
  );

  fcb_back u_back (
    .clk, .rst, .has_kernal, .debounce_cycles,
    .q_valid, .q_ready, .q_item,
    .out_valid, .out_ready, .drive_bus, .read_data,
    .game_line, .exrom_line, .nmi_line, .led_on
  );
endmodule
`default_nettype wire

>>> design/fcb_checker.sv
`default_nettype none
module fcb_checker (
  input wire       clk,
  input wire       rst,
  input wire       in_ready,
  input wire       out_valid,
  input wire       out_ready,
  input wire       drive_bus,
  input wire [7:0] read_data
);
  // undriven cycles carry zero data
  a_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !drive_bus |-> read_data == 8'd0) else $error("data without drive");
  // output holds while stalled
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(read_data))
    else $error("output dropped");
  // nothing out right after reset
  a_rst: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("output after reset");
  // queue is empty and open after reset
  a_ready: assert property (@(posedge clk) rst |=> in_ready)
    else $error("input blocked after reset");
endmodule

bind freezer_cartridge_bus_logic fcb_checker u_chk (
  .clk, .rst, .in_ready, .out_valid, .out_ready, .drive_bus, .read_data
);
`default_nettype wire
